// ----- design/tsp_boltzmann_unit_update_unit_assert.svh -----
// Assertion macros for the Boltzmann unit engine
`ifndef TSP_BOLTZMANN_UNIT_UPDATE_UNIT_ASSERT_SVH
`define TSP_BOLTZMANN_UNIT_UPDATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BMU_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BMU_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BMU_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define BMU_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- design/tbu_pkg.sv -----
package tbu_pkg;

    localparam int SIG_LAST = 32;

    // cities on the tour; a unit index packs city and tour position as bit fields
    localparam int CITIES = 8;

    typedef enum logic [2:0] {
        REQ_WRITE_DIST = 3'd0,
        REQ_SET_UNIT   = 3'd1,
        REQ_UPDATE     = 3'd2,
        REQ_CLEAR      = 3'd3,
        REQ_COMMIT     = 3'd4,
        REQ_READ       = 3'd5
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DIVIDE,
        ST_SIGMOID,
        ST_INTERP,
        ST_FINISH,
        ST_GLOBAL,
        ST_OUT
    } state_t;

    localparam logic [0:0] CFG_GAMMA = 1'b0;
    localparam logic [0:0] CFG_TEMP  = 1'b1;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [15:0] sig_lookup(input logic [5:0] k);
        logic [15:0] v;
        begin
            case (k)
                6'd0:  v = 16'd32768; 6'd1:  v = 16'd36843; 6'd2:  v = 16'd40793;
                6'd3:  v = 16'd44511; 6'd4:  v = 16'd47911; 6'd5:  v = 16'd50941;
                6'd6:  v = 16'd53581; 6'd7:  v = 16'd55834; 6'd8:  v = 16'd57724;
                6'd9:  v = 16'd59287; 6'd10: v = 16'd60565; 6'd11: v = 16'd61598;
                6'd12: v = 16'd62428; 6'd13: v = 16'd63090; 6'd14: v = 16'd63615;
                6'd15: v = 16'd64030; 6'd16: v = 16'd64357; 6'd17: v = 16'd64614;
                6'd18: v = 16'd64816; 6'd19: v = 16'd64974; 6'd20: v = 16'd65097;
                6'd21: v = 16'd65194; 6'd22: v = 16'd65269; 6'd23: v = 16'd65328;
                6'd24: v = 16'd65374; 6'd25: v = 16'd65410; 6'd26: v = 16'd65438;
                6'd27: v = 16'd65459; 6'd28: v = 16'd65476; 6'd29: v = 16'd65489;
                6'd30: v = 16'd65500; 6'd31: v = 16'd65508;
                default: v = 16'd65514;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- design/tsp_boltzmann_unit_update_unit.sv -----
// Boltzmann-machine unit engine for the travelling-salesman problem, built for
// eight cities (64 units). Each request returns one item. Distance writes,
// set, read and counter clear pass through the finish and output states before
// the next item is taken; commit majority walks all CITIES*CITIES units, one
// per cycle. An update walks all CITIES*CITIES units through one shared
// accumulator, then drains the last term (distance read from a registered
// memory), then runs a restoring divide of |sum|*512 by temperature, then a
// table lookup and one multiply for interpolation; no new request is taken
// until the result has left the output state, which waits on out_stall.
// Clear counters resets a valid bit per unit, so it takes no sweep. The sum
// is kept in units of 1/512; the sigmoid table covers 0..8 in steps of 1/4
// and is mirrored for negative sums. in_stall is high while a request is in
// flight; the result holds until out_stall drops.
module tsp_boltzmann_unit_update_unit #(
    parameter int PROB_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [5:0]  unit_index,
    input  logic [2:0]  city_from,
    input  logic [2:0]  city_to,
    input  logic [15:0] distance_value,
    input  logic        unit_value,
    input  logic [15:0] random_draw,
    input  logic        count_enable,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        unit_state,
    output logic [15:0] probability,
    output logic [15:0] on_count,
    output logic [15:0] off_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tbu_pkg::*;
`include "tsp_boltzmann_unit_update_unit_assert.svh"

    localparam int UNITS = CITIES * CITIES;
    localparam int UW    = $clog2(UNITS);
    localparam int CW    = $clog2(CITIES);
    localparam int SUM_W = 24;
    localparam int NUM_W = 40;

    // ---------------- state ----------------
    state_t state_reg, state_next;
    logic [15:0] gamma_reg, temp_reg;
    logic [UNITS-1:0] bits_reg;
    logic [UNITS-1:0] cnt_valid_reg;
    logic [15:0] on_mem  [UNITS];
    logic [15:0] off_mem [UNITS];
    logic [15:0] dist_mem[UNITS];

    logic [2:0]  req_reg;
    logic [5:0]  idx_reg;
    logic        idx_ok_reg;
    logic [15:0] draw_reg;
    logic        cen_reg;
    logic [UW:0] j_reg;
    logic        pend_reg;       // a distance read is in flight
    logic        pg_reg;         // a penalty term is queued for the sum
    logic signed [SUM_W-1:0] sum_reg;
    logic [NUM_W-1:0] xq_reg;
    logic [15:0] base_reg, diff_reg;
    logic [7:0]  frac_reg;
    logic [15:0] prob_reg;
    logic        res_state_reg;
    logic [15:0] res_on_reg, res_off_reg;
    logic [15:0] dist_rd_reg, on_rd_reg, off_rd_reg;
    logic        out_valid_reg;

    logic idx_ok;
    assign idx_ok = {2'b00, unit_index} < 8'(UNITS);

    logic [UW-1:0] iu;
    assign iu = idx_reg[UW-1:0];
    logic [CW-1:0] ci, pi;
    assign ci = iu[UW-1:CW];
    assign pi = iu[CW-1:0];

    // ---------------- divider ----------------
    logic div_start;
    logic [NUM_W-1:0] div_q;
    div_status_t div_st;
    logic [SUM_W-1:0] mag;
    assign mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    tbu_divider #(.NUM_W(NUM_W), .DEN_W(16)) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .numer  ({7'd0, mag, 9'd0}),
        .denom  ((temp_reg == 16'd0) ? 16'd1 : temp_reg),
        .quot   (div_q),
        .status (div_st)
    );

    // ---------------- sweep term ----------------
    logic [UW-1:0] jj;
    logic [CW-1:0] cj, pj;
    logic same_rc, nbr, act;
    assign jj = j_reg[UW-1:0];
    assign cj = jj[UW-1:CW];
    assign pj = jj[CW-1:0];
    assign act = (j_reg < (UW+1)'(UNITS)) && (jj != iu) && bits_reg[jj];
    assign same_rc = (ci == cj) || (pi == pj);
    assign nbr = (pj == ((pi == CW'(CITIES-1)) ? '0 : pi + 1'b1))
              || (pi == ((pj == CW'(CITIES-1)) ? '0 : pj + 1'b1));

    // ---------------- next state ----------------
    logic in_acc;
    assign in_acc = in_valid && !in_stall;
    logic sweep_last;
    assign sweep_last = (j_reg == (UW+1)'(UNITS)) && !pend_reg && !pg_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    if (req_type == REQ_UPDATE && idx_ok)
                        state_next = ST_SWEEP;
                    else if (req_type == REQ_COMMIT)
                        state_next = ST_GLOBAL;
                    else
                        state_next = ST_FINISH;
                end
            ST_SWEEP:   if (sweep_last) state_next = ST_DIVIDE;
            ST_DIVIDE:  if (div_st.done) state_next = ST_SIGMOID;
            ST_SIGMOID: state_next = ST_INTERP;
            ST_INTERP:  state_next = ST_FINISH;
            ST_GLOBAL:  if (j_reg == (UW+1)'(UNITS)) state_next = ST_FINISH;
            ST_FINISH:  state_next = ST_OUT;
            ST_OUT:     if (!out_stall) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        cfg_ready = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_SWEEP) && sweep_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------- interpolation ----------------
    logic [23:0] interp_prod;
    logic [16:0] p_pos;
    logic [16:0] p_sgn;
    logic [15:0] p_final;
    logic [15:0] prob_mask;
    assign interp_prod = diff_reg * frac_reg;
    assign p_pos = {1'b0, base_reg} + 17'(interp_prod[23:8]);
    assign p_sgn = sum_reg[SUM_W-1] ? (17'h10000 - p_pos) : p_pos;
    assign prob_mask = (PROB_BITS >= 16) ? 16'hFFFF
                     : ~((16'd1 << ((16 - PROB_BITS) & 15)) - 16'd1);
    assign p_final = p_sgn[15:0] & prob_mask;

    logic [15:0] on_cur, off_cur;
    assign on_cur  = cnt_valid_reg[iu] ? on_rd_reg  : 16'd0;
    assign off_cur = cnt_valid_reg[iu] ? off_rd_reg : 16'd0;

    logic up_bit;
    assign up_bit = (draw_reg <= prob_reg);

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg     <= 16'd256;
            temp_reg      <= 16'd25600;
            bits_reg      <= '0;
            cnt_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            j_reg         <= '0;
            pend_reg      <= 1'b0;
            pg_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_GAMMA)
                    gamma_reg <= cfg_data;
                else
                    temp_reg <= cfg_data;
            end
            if (in_acc)
                j_reg <= '0;
            // queue this unit's term; it lands on the sum next cycle
            pend_reg <= (state_reg == ST_SWEEP) && act && !same_rc && nbr;
            pg_reg   <= (state_reg == ST_SWEEP) && act && same_rc;
            case (state_reg)
                ST_IDLE:
                    if (in_acc)
                    begin
                        if (req_type == REQ_SET_UNIT && idx_ok)
                            bits_reg[unit_index[UW-1:0]] <= unit_value;
                        if (req_type == REQ_CLEAR)
                            cnt_valid_reg <= '0;
                    end
                ST_SWEEP:
                    if (j_reg != (UW+1)'(UNITS))
                        j_reg <= j_reg + 1'b1;
                ST_GLOBAL:
                    if (j_reg != (UW+1)'(UNITS))
                    begin
                        bits_reg[jj] <= cnt_valid_reg[jj] && (on_rd_reg > off_rd_reg);
                        j_reg <= j_reg + 1'b1;
                    end
                ST_FINISH:
                    if (req_reg == REQ_UPDATE && idx_ok_reg)
                    begin
                        bits_reg[iu] <= up_bit;
                        if (cen_reg)
                            cnt_valid_reg[iu] <= 1'b1;
                    end
                default: ;
            endcase
            if (state_reg == ST_FINISH)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    logic [UW-1:0] rd_addr;

    // Read address for counters: during commit the next sweep unit, else the target.
    // The last commit cycle fetches the target so the result sees its counters.
    always_comb
    begin
        if (state_reg == ST_GLOBAL)
            rd_addr = (j_reg == (UW+1)'(UNITS)) ? iu : jj + 1'b1;
        else if (state_reg == ST_IDLE)
            rd_addr = (req_type == REQ_COMMIT) ? '0 : unit_index[UW-1:0];
        else
            rd_addr = iu;
    end

    logic [UW-1:0] dist_addr;
    assign dist_addr = {ci, cj};

    // ---------------- payload registers and memories ----------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SWEEP)
            dist_rd_reg <= dist_mem[dist_addr];
        on_rd_reg  <= on_mem[rd_addr];
        off_rd_reg <= off_mem[rd_addr];

        if (in_acc)
        begin
            req_reg    <= req_type;
            idx_reg    <= unit_index;
            draw_reg   <= random_draw;
            cen_reg    <= count_enable;
            idx_ok_reg <= idx_ok;
            sum_reg    <= SUM_W'(gamma_reg);
            prob_reg   <= 16'd0;
            if (req_type == REQ_WRITE_DIST && {1'b0, city_from} < 4'(CITIES)
                && {1'b0, city_to} < 4'(CITIES))
                dist_mem[{city_from[CW-1:0], city_to[CW-1:0]}] <= distance_value;
        end

        case (state_reg)
            ST_SWEEP:
            begin
                if (pend_reg)
                    sum_reg <= sum_reg - SUM_W'({dist_rd_reg, 1'b0});
                else if (pg_reg)
                    sum_reg <= sum_reg - SUM_W'({gamma_reg, 1'b0});
            end
            ST_SIGMOID:
            begin
                if (div_q >= NUM_W'(SIG_LAST * 256))
                begin
                    base_reg <= sig_lookup(6'(SIG_LAST));
                    diff_reg <= 16'd0;
                    frac_reg <= 8'd0;
                end
                else
                begin
                    base_reg <= sig_lookup({1'b0, div_q[12:8]});
                    diff_reg <= sig_lookup({1'b0, div_q[12:8]} + 6'd1)
                              - sig_lookup({1'b0, div_q[12:8]});
                    frac_reg <= div_q[7:0];
                end
            end
            ST_INTERP:
                prob_reg <= p_final;
            ST_FINISH:
            begin
                if (req_reg == REQ_UPDATE && idx_ok_reg && cen_reg)
                begin
                    if (up_bit)
                    begin
                        on_mem[iu]  <= (on_cur == 16'hFFFF) ? on_cur : on_cur + 1'b1;
                        off_mem[iu] <= off_cur;
                    end
                    else
                    begin
                        on_mem[iu]  <= on_cur;
                        off_mem[iu] <= (off_cur == 16'hFFFF) ? off_cur : off_cur + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Result capture: bits and counters are final in the cycle after FINISH.
    logic [15:0] res_on_w, res_off_w;
    always_comb
    begin
        res_on_w  = on_cur;
        res_off_w = off_cur;
        if (req_reg == REQ_UPDATE && cen_reg)
        begin
            if (up_bit)
                res_on_w  = (on_cur == 16'hFFFF) ? on_cur : on_cur + 1'b1;
            else
                res_off_w = (off_cur == 16'hFFFF) ? off_cur : off_cur + 1'b1;
        end
        if (req_reg == REQ_CLEAR)
        begin
            res_on_w  = 16'd0;
            res_off_w = 16'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH)
        begin
            res_state_reg <= (req_reg == REQ_UPDATE) ? up_bit : bits_reg[iu];
            res_on_reg    <= res_on_w;
            res_off_reg   <= res_off_w;
        end
    end

    assign out_valid   = out_valid_reg;
    assign unit_state  = idx_ok_reg & res_state_reg;
    assign probability = idx_ok_reg ? prob_reg : 16'd0;
    assign on_count    = idx_ok_reg ? res_on_reg : 16'd0;
    assign off_count   = idx_ok_reg ? res_off_reg : 16'd0;

    // ---------------- assertions ----------------
    `BMU_ASSERT_NEVER(a_no_accept_busy, clk, rst_n,
        in_valid && !in_stall && state_reg != ST_IDLE, "item accepted while busy")
    `BMU_ASSERT_IMPL(a_out_only_in_out, clk, rst_n,
        out_valid |-> state_reg == ST_OUT, "result outside output state")
    `BMU_ASSERT_IMPL(a_div_start_sweep, clk, rst_n,
        div_start |=> state_reg == ST_DIVIDE, "divider start without divide state")
    `BMU_ASSERT_NEVER(a_cfg_busy, clk, rst_n,
        cfg_ready && state_reg != ST_IDLE, "config ready while busy")

endmodule

// ----- design/tbu_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module tbu_divider #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [NUM_W-1:0]       numer,
    input  logic [DEN_W-1:0]       denom,
    output logic [NUM_W-1:0]       quot,
    output tbu_pkg::div_status_t   status
);
    import tbu_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W+1:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            q_next    = numer;
            r_next    = '0;
            d_next    = denom;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in next dividend bit, try subtract
            trial = {r_reg, q_reg[NUM_W-1]} - {2'b00, d_reg};
            if (!trial[DEN_W+1])
            begin
                r_next = trial[DEN_W:0];
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quot        = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
